// ===== hdl/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== hdl/mhpq_req_if.sv =====
interface mhpq_req_if #(
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8
);
  logic                valid;
  logic                ready;
  logic                command;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, command, key, tag, input ready);
  modport sink   (input valid, command, key, tag, output ready);
endinterface

// ===== hdl/mhpq_rsp_if.sv =====
interface mhpq_rsp_if
  import mhpq_pkg::*;
#(
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8,
  parameter int unsigned OCC_W    = 7
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, out_key, out_tag, status, occupancy, input ready);
  modport sink   (input valid, out_key, out_tag, status, occupancy, output ready);
endinterface

// ===== hdl/min_heap_priority_queue_top.sv =====
// sequencing: an insert sifts up the heap and a pop sifts down it before the result is valid;
// each heap level costs a registered memory read and a compare/write
// throughput: one request at a time, ready returns the cycle after the result is queued,
// and the sequencer holds its done state while the result side does not keep up
// reset: rst_ni async active low clears the entry count, sequencer and result valid;
// heap memory contents are not cleared
module min_heap_priority_queue_top
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_req_if.sink   req_i,
  mhpq_rsp_if.source rsp_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = ADDR_W + 2;
  localparam int unsigned ENT_W  = KEY_BITS + TAG_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP    = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN     = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic [ENT_W-1:0]    item_q, item_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;

  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] out_key_q, out_key_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [CNT_W-1:0]    out_occ_q, out_occ_d;

  logic [ENT_W-1:0]    heap_mem_q [CAPACITY];
  logic [ENT_W-1:0]    rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]   raddr_a, raddr_b, waddr;
  logic [ENT_W-1:0]    wdata;
  logic                we;

  logic [IDX_W-1:0]    left_w, right_w, cnt_x;
  logic [ADDR_W-1:0]   parent;
  logic [CNT_W-1:0]    last_w;
  logic                pick_right;
  logic [ENT_W-1:0]    best_ent;
  logic [ADDR_W-1:0]   best_idx;
  logic                req_acc;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // children of the hole are 2p+1 and 2p+2, parent is (p-1)/2
  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = IDX_W'(left_w + 1'b1);
  assign cnt_x   = IDX_W'(cnt_q);
  assign parent  = ADDR_W'((pos_q - 1'b1) >> 1);
  assign last_w  = CNT_W'(cnt_q - 1'b1);

  // smaller child wins, left on a tie
  assign pick_right = (right_w < cnt_x) &&
                      (rd_b_q[ENT_W-1:TAG_BITS] < rd_a_q[ENT_W-1:TAG_BITS]);
  assign best_ent   = pick_right ? rd_b_q : rd_a_q;
  assign best_idx   = pick_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    item_d      = item_q;
    res_key_d   = res_key_q;
    res_tag_d   = res_tag_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    out_st_d    = out_st_q;
    out_occ_d   = out_occ_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = item_q;
    raddr_a     = '0;
    raddr_b     = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          res_key_d = '0;
          res_tag_d = '0;
          res_st_d  = ST_OK;
          if (req_i.command == CMD_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              item_d  = {req_i.key, req_i.tag};
              pos_d   = cnt_q[ADDR_W-1:0];
              cnt_d   = CNT_W'(cnt_q + 1'b1);
              state_d = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              // fetch root and last entry together
              raddr_a = '0;
              raddr_b = last_w[ADDR_W-1:0];
              cnt_d   = last_w;
              state_d = S_POP;
            end
          end
        end
      end
      S_POP: begin
        res_key_d = rd_a_q[ENT_W-1:TAG_BITS];
        res_tag_d = rd_a_q[TAG_BITS-1:0];
        item_d    = rd_b_q;
        pos_d     = '0;
        state_d   = (cnt_q == '0) ? S_DONE : S_DN;
      end
      S_UP: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr_a = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (item_q[ENT_W-1:TAG_BITS] < rd_a_q[ENT_W-1:TAG_BITS]) begin
          // parent moves down into the hole
          wdata   = rd_a_q;
          pos_d   = parent;
          state_d = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN: begin
        if (left_w >= cnt_x) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr_a = left_w[ADDR_W-1:0];
          raddr_b = right_w[ADDR_W-1:0];
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (best_ent[ENT_W-1:TAG_BITS] < item_q[ENT_W-1:TAG_BITS]) begin
          // smaller child moves up into the hole
          wdata   = best_ent;
          pos_d   = best_idx;
          state_d = S_DN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_key_d   = res_key_q;
          out_tag_d   = res_tag_q;
          out_st_d    = res_st_q;
          out_occ_d   = cnt_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    item_q    <= item_d;
    res_key_q <= res_key_d;
    res_tag_q <= res_tag_d;
    res_st_q  <= res_st_d;
    out_key_q <= out_key_d;
    out_tag_q <= out_tag_d;
    out_st_q  <= out_st_d;
    out_occ_q <= out_occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[waddr] <= wdata;
    end
    rd_a_q <= heap_mem_q[raddr_a];
    rd_b_q <= heap_mem_q[raddr_b];
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_key   = out_key_q;
  assign rsp_o.out_tag   = out_tag_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.occupancy = out_occ_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.command == CMD_INSERT && cnt_q != CNT_W'(CAPACITY))
    |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("insert did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.command == CMD_POP && cnt_q != '0)
    |=> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
    else $error("pop did not remove one entry");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> rsp_o.occupancy == CNT_W'(CAPACITY))
    else $error("full status with heap not full");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_EMPTY)
    |-> (rsp_o.occupancy == '0 && rsp_o.out_key == '0 && rsp_o.out_tag == '0))
    else $error("empty status with nonzero fields");
`endif

endmodule
